[rtl/core/rgbhe_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhe_pkg
// Shared types, constants and helpers for the per-channel histogram equalizer.
// ----------------------------------------------------------------------------
package rgbhe_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int LEVELS     = 256;
    localparam int NCHAN      = 3;
    localparam int NBINS      = 256;
    localparam int BIN_AW     = $clog2(NBINS);
    localparam int PIX_W      = $clog2(MAX_PIXELS + 1);
    localparam int QUO_W      = 8;
    localparam int NUM_W      = PIX_W + QUO_W;
    localparam int STEP_W     = $clog2(QUO_W);

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_COUNT = 2'd1,
        FUNC_MAP   = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_BLD_RD,
        S_BLD_ACC,
        S_BLD_DIV,
        S_BLD_WR,
        S_MAP_RD,
        S_MAP_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clr_write;
        logic cnt_read;
        logic cnt_write;
        logic bld_start;
        logic bld_read;
        logic bld_acc;
        logic bld_div;
        logic bld_write;
        logic map_read;
        logic map_out;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  full;
        logic  ready;
        logic  addr_last;
        logic  step_zero;
        logic  out_free;
    } status_t;

    // clamp a channel value to the top level
    function automatic logic [7:0] clamp_level(logic [7:0] v);
        logic [7:0] r;
        r = v;
        if ({24'd0, v} > LEVELS - 1)
            r = 8'(LEVELS - 1);
        return r;
    endfunction

endpackage

[rtl/core/rgb_histogram_equalizer.sv]
// ----------------------------------------------------------------------------
// rgb_histogram_equalizer
// Per-channel histogram equalization of 8-bit three-channel pixels.
// ----------------------------------------------------------------------------
// A clear word zeroes the histograms with a sweep over all 256 bins (the
// same sweep runs once after reset, with item_stall high). A count word is
// a read-modify-write of the bin memories and gives no result; a count word
// with the pixel counter full, or a word with the unused code, is taken in
// the idle state and does nothing. A map word reads the remap memories when
// the table is current; the first map word after reset, a clear or a count
// first rebuilds the table, 256 bins, each with a read, an accumulate, 8
// shift-subtract divide steps and a write.
// Exactly one result word comes out for each map word through an output
// register; a stalled result holds the block in its last step.
module rgb_histogram_equalizer
    import rgbhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] func,
    input  logic [7:0] chan0,
    input  logic [7:0] chan1,
    input  logic [7:0] chan2,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out0,
    output logic [7:0] out1,
    output logic [7:0] out2
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    rgbhe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // storage and arithmetic
    rgbhe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (func),
        .chan0        (chan0),
        .chan1        (chan1),
        .chan2        (chan2),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out0         (out0),
        .out1         (out1),
        .out2         (out2)
    );

endmodule

[rtl/core/rgbhe_ctrl.sv]
// ----------------------------------------------------------------------------
// rgbhe_ctrl
// Sequencer: clear sweep, count read-modify-write, table build, remap lookup.
// ----------------------------------------------------------------------------
module rgbhe_ctrl
    import rgbhe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:
            begin
                if (status.addr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (status.func)
                        FUNC_CLEAR: state_next = S_CLR;
                        FUNC_COUNT: state_next = status.full ? S_IDLE : S_CNT_RD;
                        FUNC_MAP:   state_next = status.ready ? S_MAP_RD : S_BLD_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD:  state_next = S_CNT_WR;
            S_CNT_WR:  state_next = S_IDLE;
            S_BLD_RD:  state_next = S_BLD_ACC;
            S_BLD_ACC: state_next = S_BLD_DIV;
            S_BLD_DIV:
            begin
                if (status.step_zero)
                    state_next = S_BLD_WR;
            end
            S_BLD_WR:  state_next = status.addr_last ? S_MAP_RD : S_BLD_RD;
            S_MAP_RD:  state_next = S_MAP_OUT;
            S_MAP_OUT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_CLR:     cmd.clr_write = 1'b1;
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.func == FUNC_CLEAR)
                        cmd.clr_start = 1'b1;
                    if (status.func == FUNC_MAP && !status.ready)
                        cmd.bld_start = 1'b1;
                end
            end
            S_CNT_RD:  cmd.cnt_read  = 1'b1;
            S_CNT_WR:  cmd.cnt_write = 1'b1;
            S_BLD_RD:  cmd.bld_read  = 1'b1;
            S_BLD_ACC: cmd.bld_acc   = 1'b1;
            S_BLD_DIV: cmd.bld_div   = 1'b1;
            S_BLD_WR:  cmd.bld_write = 1'b1;
            S_MAP_RD:  cmd.map_read  = 1'b1;
            S_MAP_OUT: cmd.map_out   = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

[rtl/core/rgbhe_datapath.sv]
// ----------------------------------------------------------------------------
// rgbhe_datapath
// Bin memories, remap memories, cumulative sums, shift-subtract dividers and
// the output register.
// ----------------------------------------------------------------------------
module rgbhe_datapath
    import rgbhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  func,
    input  logic [7:0]  chan0,
    input  logic [7:0]  chan1,
    input  logic [7:0]  chan2,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  out0,
    output logic [7:0]  out1,
    output logic [7:0]  out2
);

    logic [PIX_W-1:0]  bin_mem [NCHAN][NBINS];
    logic [7:0]        map_mem [NCHAN][NBINS];

    logic [BIN_AW-1:0] px_reg    [NCHAN];
    logic [PIX_W-1:0]  bin_rd_reg[NCHAN];
    logic [7:0]        map_rd_reg[NCHAN];
    logic [PIX_W-1:0]  cum_reg   [NCHAN];
    logic [NUM_W-1:0]  rem_reg   [NCHAN];
    logic [QUO_W-1:0]  quo_reg   [NCHAN];
    logic [7:0]        out_reg   [NCHAN];
    logic [PIX_W-1:0]  cum_next  [NCHAN];
    logic [NUM_W-1:0]  den_shift;
    logic [7:0]        chan_in   [NCHAN];

    logic [PIX_W-1:0]  total_reg;
    logic              ready_reg;
    logic [BIN_AW-1:0] addr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;

    assign chan_in[0] = chan0;
    assign chan_in[1] = chan1;
    assign chan_in[2] = chan2;

    // status toward the sequencer
    assign status.func      = func_t'(func);
    assign status.full      = ({{(32-PIX_W){1'b0}}, total_reg} >= MAX_PIXELS);
    assign status.ready     = ready_reg;
    assign status.addr_last = (addr_reg == BIN_AW'(NBINS - 1));
    assign status.step_zero = (step_reg == '0);
    assign status.out_free  = !out_valid_reg || !result_stall;

    // running sums for this bin
    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
            cum_next[c] = cum_reg[c] + bin_rd_reg[c];
        den_shift = NUM_W'(total_reg) << step_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            ready_reg     <= 1'b0;
            addr_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                total_reg <= '0;
                ready_reg <= 1'b0;
            end
            if (cmd.cnt_write)
            begin
                total_reg <= total_reg + 1'b1;
                ready_reg <= 1'b0;
            end
            if (cmd.clr_start || cmd.bld_start)
                addr_reg <= '0;
            else if (cmd.clr_write || cmd.bld_write)
                addr_reg <= addr_reg + 1'b1;
            if (cmd.bld_write && status.addr_last)
                ready_reg <= 1'b1;
            if (cmd.bld_acc)
                step_reg <= STEP_W'(QUO_W - 1);
            else if (cmd.bld_div)
                step_reg <= step_reg - 1'b1;
            if (cmd.map_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            if (cmd.capture)
                px_reg[c] <= BIN_AW'(clamp_level(chan_in[c]));
            if (cmd.clr_write)
                bin_mem[c][addr_reg] <= '0;
            if (cmd.cnt_read)
                bin_rd_reg[c] <= bin_mem[c][px_reg[c]];
            if (cmd.bld_read)
                bin_rd_reg[c] <= bin_mem[c][addr_reg];
            if (cmd.cnt_write)
                bin_mem[c][px_reg[c]] <= bin_rd_reg[c] + 1'b1;
            if (cmd.bld_start)
                cum_reg[c] <= '0;
            if (cmd.bld_acc)
            begin
                cum_reg[c] <= cum_next[c];
                rem_reg[c] <= NUM_W'(cum_next[c]) * NUM_W'(LEVELS - 1);
                quo_reg[c] <= '0;
            end
            // one quotient bit per step
            if (cmd.bld_div && rem_reg[c] >= den_shift)
            begin
                rem_reg[c]           <= rem_reg[c] - den_shift;
                quo_reg[c][step_reg] <= 1'b1;
            end
            if (cmd.bld_write)
            begin
                if (total_reg == '0 || {{(32-BIN_AW){1'b0}}, addr_reg} >= LEVELS)
                    map_mem[c][addr_reg] <= '0;
                else
                    map_mem[c][addr_reg] <= quo_reg[c];
            end
            if (cmd.map_read)
                map_rd_reg[c] <= map_mem[c][px_reg[c]];
            if (cmd.map_out)
                out_reg[c] <= map_rd_reg[c];
        end
    end

    assign result_valid = out_valid_reg;
    assign out0         = out_reg[0];
    assign out1         = out_reg[1];
    assign out2         = out_reg[2];

endmodule
